// ===== hw/rtl/flrs_pkg.sv =====
// ----------------------------------------------------------------------------
// flrs_pkg
// shared types, constants and helper functions of the frame label run
// segmenter
// ----------------------------------------------------------------------------
package flrs_pkg;

  localparam int unsigned FRAME_BITS  = 20;
  localparam int unsigned LABEL_BITS  = 16;
  localparam int unsigned IN_LABEL_W  = 16;
  localparam int unsigned SEG_FRAME_W = 20;
  localparam int unsigned SEG_LABEL_W = 16;
  localparam int unsigned LIKE_W      = 32;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic SCORE_EN_RESET = 1'b1;

  typedef struct packed {
    logic [SEG_FRAME_W-1:0]   start;
    logic [SEG_FRAME_W-1:0]   stop;
    logic [SEG_LABEL_W-1:0]   label;
    logic signed [LIKE_W-1:0] score;
    logic                     fin;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic [LABEL_BITS-1:0] label_in(input logic [IN_LABEL_W-1:0] x);
    logic [IN_LABEL_W+LABEL_BITS-1:0] tmp;
    tmp = {{LABEL_BITS{1'b0}}, x};
    return tmp[LABEL_BITS-1:0];
  endfunction

  function automatic logic [SEG_LABEL_W-1:0] label_out(input logic [LABEL_BITS-1:0] x);
    logic [SEG_LABEL_W+LABEL_BITS-1:0] tmp;
    tmp = {{SEG_LABEL_W{1'b0}}, x};
    return tmp[SEG_LABEL_W-1:0];
  endfunction

  function automatic logic [SEG_FRAME_W-1:0] frame_out(input logic [FRAME_BITS-1:0] x);
    logic [SEG_FRAME_W+FRAME_BITS-1:0] tmp;
    tmp = {{SEG_FRAME_W{1'b0}}, x};
    return tmp[SEG_FRAME_W-1:0];
  endfunction

  // saturating difference of two q16.16 values, zero when scoring is off
  function automatic logic signed [LIKE_W-1:0] gain(input logic signed [LIKE_W-1:0] e,
                                                    input logic signed [LIKE_W-1:0] b,
                                                    input logic en);
    logic signed [LIKE_W:0] d;
    logic signed [LIKE_W-1:0] r;
    d = {e[LIKE_W-1], e} - {b[LIKE_W-1], b};
    if (d[LIKE_W] != d[LIKE_W-1]) begin
      r = d[LIKE_W] ? {1'b1, {(LIKE_W-1){1'b0}}} : {1'b0, {(LIKE_W-1){1'b1}}};
    end else begin
      r = d[LIKE_W-1:0];
    end
    if (!en) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/flrs_core.sv =====
// ----------------------------------------------------------------------------
// flrs_core
// input register, run tracking state and segment close logic; produces up to
// two results per frame toward the output queue
// ----------------------------------------------------------------------------
module flrs_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [flrs_pkg::IN_LABEL_W-1:0]     state_label_i,
  input  logic signed [flrs_pkg::LIKE_W-1:0]  cumulative_likelihood_i,
  input  logic                                segment_boundary_i,
  input  logic                                last_frame_i,
  input  logic                                score_en_i,
  input  logic                                room_i,
  output flrs_pkg::push_t                     push_o
);

  logic                                vld_q;
  logic [flrs_pkg::LABEL_BITS-1:0]     lab_q;
  logic signed [flrs_pkg::LIKE_W-1:0]  like_q;
  logic                                bnd_q;
  logic                                last_q;

  logic [flrs_pkg::LABEL_BITS-1:0]     prev_label_q, prev_label_d;
  logic signed [flrs_pkg::LIKE_W-1:0]  prev_like_q, prev_like_d;
  logic signed [flrs_pkg::LIKE_W-1:0]  base_q, base_d;
  logic [flrs_pkg::FRAME_BITS-1:0]     seg_start_q, seg_start_d;
  logic [flrs_pkg::FRAME_BITS-1:0]     frame_q, frame_d;
  logic                                open_q, open_d;

  logic                                adv;
  logic                                change;
  logic                                close;
  logic [flrs_pkg::FRAME_BITS-1:0]     start1;
  logic signed [flrs_pkg::LIKE_W-1:0]  base1;

  assign adv        = vld_q & room_i;
  assign in_stall_o = vld_q & ~room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      lab_q  <= flrs_pkg::label_in(state_label_i);
      like_q <= cumulative_likelihood_i;
      bnd_q  <= segment_boundary_i;
      last_q <= last_frame_i;
    end
  end

  always_comb begin
    change = open_q && (lab_q != prev_label_q);
    close  = bnd_q | last_q;
    start1 = (change || !open_q) ? frame_q : seg_start_q;
    base1  = change ? prev_like_q : base_q;

    push_o.v0       = adv & change;
    push_o.r0.start = flrs_pkg::frame_out(seg_start_q);
    push_o.r0.stop  = flrs_pkg::frame_out(frame_q - 1'b1);
    push_o.r0.label = flrs_pkg::label_out(prev_label_q);
    push_o.r0.score = flrs_pkg::gain(prev_like_q, base_q, score_en_i);
    push_o.r0.fin   = 1'b0;

    push_o.v1       = adv & close;
    push_o.r1.start = flrs_pkg::frame_out(start1);
    push_o.r1.stop  = flrs_pkg::frame_out(frame_q);
    push_o.r1.label = flrs_pkg::label_out(lab_q);
    push_o.r1.score = flrs_pkg::gain(like_q, base1, score_en_i);
    push_o.r1.fin   = last_q;

    prev_label_d = lab_q;
    prev_like_d  = like_q;
    seg_start_d  = start1;
    if (last_q) begin
      base_d  = '0;
      open_d  = 1'b0;
      frame_d = '0;
    end else begin
      base_d  = bnd_q ? like_q : base1;
      open_d  = ~bnd_q;
      frame_d = frame_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_label_q <= '0;
      prev_like_q  <= '0;
      base_q       <= '0;
      seg_start_q  <= '0;
      frame_q      <= '0;
      open_q       <= 1'b0;
    end else if (adv) begin
      prev_label_q <= prev_label_d;
      prev_like_q  <= prev_like_d;
      base_q       <= base_d;
      seg_start_q  <= seg_start_d;
      frame_q      <= frame_d;
      open_q       <= open_d;
    end
  end

  // label change result needs an open segment
  a_change_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v0 |-> open_q)
    else $error("label change close without open segment");

  // frame counter restarts after the last frame
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> (frame_q == '0 && !open_q && base_q == '0))
    else $error("state not restarted after last frame");

endmodule

// ===== hw/rtl/flrs_outq.sv =====
// ----------------------------------------------------------------------------
// flrs_outq
// small result queue, takes up to two results per cycle and hands out one unless stalled
// ----------------------------------------------------------------------------
module flrs_outq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  flrs_pkg::push_t                     push_i,
  output logic                                room_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output flrs_pkg::res_t                      head_o
);

  flrs_pkg::res_t                  mem_q [flrs_pkg::Q_DEPTH];
  logic [flrs_pkg::Q_PTR_W-1:0]    wr_q, wr_d;
  logic [flrs_pkg::Q_PTR_W-1:0]    rd_q, rd_d;
  logic [flrs_pkg::Q_CNT_W-1:0]    cnt_q, cnt_d;
  logic                            pop;
  logic [flrs_pkg::Q_PTR_W-1:0]    wr1;
  flrs_pkg::res_t                  first;
  logic                            we0;
  logic                            we1;

  assign room_o      = cnt_q <= flrs_pkg::Q_CNT_W'(flrs_pkg::Q_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];
  assign pop         = out_valid_o & ~out_stall_i;

  always_comb begin
    we0   = push_i.v0 | push_i.v1;
    we1   = push_i.v0 & push_i.v1;
    first = push_i.v0 ? push_i.r0 : push_i.r1;
    wr1   = wr_q + 1'b1;
    wr_d  = wr_q + flrs_pkg::Q_PTR_W'(we0) + flrs_pkg::Q_PTR_W'(we1);
    rd_d  = rd_q + flrs_pkg::Q_PTR_W'(pop);
    cnt_d = cnt_q + flrs_pkg::Q_CNT_W'(we0) + flrs_pkg::Q_CNT_W'(we1)
            - flrs_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem_q[wr_q] <= first;
    end
    if (we1) begin
      mem_q[wr1] <= push_i.r1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= flrs_pkg::Q_CNT_W'(flrs_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.v0 || push_i.v1) |-> room_o)
    else $error("push without room");

endmodule

// ===== hw/rtl/frame_label_run_segmenter.sv =====
// ----------------------------------------------------------------------------
// frame_label_run_segmenter
// run-length segmentation of a decoded state path, one frame per request
// ----------------------------------------------------------------------------
// a result passes the input register and the result queue before it is offered
// throughput: one frame per cycle while the input does not stall; a frame closing
//   two segments yields two results, absorbed by a four entry result queue
// input stalls while the queue has fewer than two free entries
// reset: run state and frame counter cleared, queue empty, score_enable = 1
// ----------------------------------------------------------------------------
module frame_label_run_segmenter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [15:0]                         state_label_i,
  input  logic signed [31:0]                  cumulative_likelihood_i,
  input  logic                                segment_boundary_i,
  input  logic                                last_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [19:0]                         seg_start_o,
  output logic [19:0]                         seg_end_o,
  output logic [15:0]                         seg_label_o,
  output logic signed [31:0]                  seg_score_o,
  output logic                                final_segment_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i
);

  logic                 score_en_q;
  logic                 room;
  flrs_pkg::push_t      push;
  flrs_pkg::res_t       head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_en_q <= flrs_pkg::SCORE_EN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      score_en_q <= cfg_data_i;
    end
  end

  flrs_core u_core (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .state_label_i           (state_label_i),
    .cumulative_likelihood_i (cumulative_likelihood_i),
    .segment_boundary_i      (segment_boundary_i),
    .last_frame_i            (last_frame_i),
    .score_en_i              (score_en_q),
    .room_i                  (room),
    .push_o                  (push)
  );

  flrs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign seg_start_o     = head.start;
  assign seg_end_o       = head.stop;
  assign seg_label_o     = head.label;
  assign seg_score_o     = head.score;
  assign final_segment_o = head.fin;

endmodule
